// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the raycaster RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RGD_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define RGD_ASSERT_NEVER(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define RGD_ASSERT(name, clk, rst_n, prop)
`define RGD_ASSERT_NEVER(name, clk, rst_n, expr)
`endif
`endif

// ----- rtl/core/rgd_pkg.sv -----
// Types, constants and helpers of the grid DDA raycaster.
package rgd_pkg;

  localparam int SCREEN_W = 800;
  localparam int SCREEN_H = 600;
  localparam int GRID_W   = 8;
  localparam int GRID_H   = 8;

  localparam int COL_W      = 10;
  localparam int PIX_W      = 10;
  localparam int CELL_W     = 3;
  localparam int POS_W      = 15;
  localparam int VEC_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int FRAC_W   = 12;
  localparam int FRAC_ONE = 1 << FRAC_W;
  localparam int VEC_FRAC = 14;

  localparam int DIV_W     = $clog2(SCREEN_H + 1) + 28;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam int SC_W   = $clog2(SCREEN_W) + 2;
  localparam int CAM_W  = 16;
  localparam int PROD_W = 32;
  localparam int RAY_W  = PROD_W - VEC_FRAC;
  localparam int DQ_W   = 31;
  localparam int DLT_W  = 41;
  localparam int FRC_W  = FRAC_W + 1;
  localparam int SD_W   = 58;

  // camera coordinate by reciprocal multiply: exact while 2^CAM_SH > SCREEN_W^2
  localparam int              CAM_SH  = 2 * $clog2(SCREEN_W);
  localparam longint unsigned CAM_RCP =
    ((64'd1 << (VEC_FRAC + CAM_SH)) + 64'(SCREEN_W) - 64'd1) / 64'(SCREEN_W);
  localparam int              RCP_W   = VEC_FRAC + CAM_SH - $clog2(SCREEN_W) + 2;
  localparam int              CPR_W   = SC_W + RCP_W;

  localparam int WALK_LIMIT = GRID_W + GRID_H + 2;
  localparam int WALK_W     = $clog2(WALK_LIMIT + 1);
  localparam int GX_W       = $clog2(GRID_W);
  localparam int GY_W       = $clog2(GRID_H);
  localparam int MC_W       = ((GX_W > GY_W) ? GX_W : GY_W) + 2;
  localparam int CELLS      = GRID_W * GRID_H;
  localparam int ADDR_W     = $clog2(CELLS);

  localparam int HT_W   = $clog2(2 * SCREEN_H + 1);
  localparam int HALF_H = SCREEN_H / 2;

  localparam logic [POS_W-1:0]        RST_POS_X   = POS_W'(6144);
  localparam logic [POS_W-1:0]        RST_POS_Y   = POS_W'(22528);
  localparam logic signed [VEC_W-1:0] RST_DIR_X   = 16'sd0;
  localparam logic signed [VEC_W-1:0] RST_DIR_Y   = -16'sd16384;
  localparam logic signed [VEC_W-1:0] RST_PLANE_X = 16'sd10813;
  localparam logic signed [VEC_W-1:0] RST_PLANE_Y = 16'sd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POS_X   = 3'd0,
    CFG_POS_Y   = 3'd1,
    CFG_DIR_X   = 3'd2,
    CFG_DIR_Y   = 3'd3,
    CFG_PLANE_X = 3'd4,
    CFG_PLANE_Y = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [POS_W-1:0]        pos_x;
    logic [POS_W-1:0]        pos_y;
    logic signed [VEC_W-1:0] dir_x;
    logic signed [VEC_W-1:0] dir_y;
    logic signed [VEC_W-1:0] plane_x;
    logic signed [VEC_W-1:0] plane_y;
  } cfg_t;

  typedef enum logic [4:0] {
    CMD_NONE    = 5'd0,
    CMD_LOAD    = 5'd1,
    CMD_WRITE   = 5'd2,
    CMD_CAM_SET = 5'd4,
    CMD_MULX    = 5'd5,
    CMD_MULY    = 5'd6,
    CMD_RAY     = 5'd7,
    CMD_DX_DIV  = 5'd8,
    CMD_DX_SET  = 5'd9,
    CMD_DY_DIV  = 5'd10,
    CMD_DY_SET  = 5'd11,
    CMD_SIDE_X  = 5'd12,
    CMD_SIDE_Y  = 5'd13,
    CMD_STEP    = 5'd14,
    CMD_H_DIV   = 5'd15,
    CMD_H_SET   = 5'd16,
    CMD_EMIT    = 5'd17
  } cmd_e;

  typedef struct packed {
    logic in_op;
    logic div_done;
    logic hit;
    logic out_free;
  } status_t;

  // power-on map contents: border ring plus four inner pillars
  function automatic logic reset_wall(input logic [MC_W-1:0] x, input logic [MC_W-1:0] y);
    logic border;
    logic pillar;
    border = (x == '0) || (y == '0) || (x == MC_W'(GRID_W - 1)) || (y == MC_W'(GRID_H - 1));
    pillar = ((x == MC_W'(2)) || (x == MC_W'(4))) && ((y == MC_W'(2)) || (y == MC_W'(4)))
             && (x < MC_W'(GRID_W - 1)) && (y < MC_W'(GRID_H - 1));
    return border || pillar;
  endfunction

endpackage

// ----- rtl/core/rgd_cfg_regs.sv -----
// Viewer pose and camera configuration registers.
module rgd_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rgd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rgd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output rgd_pkg::cfg_t                  cfg_o
);
  import rgd_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_x   <= RST_POS_X;
      cfg_q.pos_y   <= RST_POS_Y;
      cfg_q.dir_x   <= RST_DIR_X;
      cfg_q.dir_y   <= RST_DIR_Y;
      cfg_q.plane_x <= RST_PLANE_X;
      cfg_q.plane_y <= RST_PLANE_Y;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_POS_X:   cfg_q.pos_x   <= cfg_data_i[POS_W-1:0];
        CFG_POS_Y:   cfg_q.pos_y   <= cfg_data_i[POS_W-1:0];
        CFG_DIR_X:   cfg_q.dir_x   <= cfg_data_i;
        CFG_DIR_Y:   cfg_q.dir_y   <= cfg_data_i;
        CFG_PLANE_X: cfg_q.plane_x <= cfg_data_i;
        CFG_PLANE_Y: cfg_q.plane_y <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/rgd_div.sv -----
// Restoring divider, one quotient bit per cycle.
module rgd_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rgd_pkg::DIV_W-1:0] dividend_i,
  input  logic [rgd_pkg::DIV_W-1:0] divisor_i,
  output logic [rgd_pkg::DIV_W-1:0] quotient_o,
  output logic                      done_o
);
  import rgd_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     rem_q;
  logic [DIV_W-1:0]     quo_q;
  logic [DIV_W-1:0]     dvs_q;
  logic [DIV_W:0]       shifted;
  logic [DIV_W:0]       diff;
  logic                 fits;

  assign shifted    = {rem_q, quo_q[DIV_W-1]};
  assign diff       = shifted - {1'b0, dvs_q};
  assign fits       = shifted >= {1'b0, dvs_q};
  assign quotient_o = quo_q;
  assign done_o     = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

endmodule

// ----- rtl/core/rgd_ctrl.sv -----
// Sequencer that steps the raycaster datapath through a cast or a map write.
module rgd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rgd_pkg::status_t   stat_i,
  output rgd_pkg::cmd_e      cmd_o
);
  import rgd_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_WRITE = 18'h00002,
    S_CAM   = 18'h00004,
    S_MULX  = 18'h00010,
    S_MULY  = 18'h00020,
    S_RAY   = 18'h00040,
    S_DX    = 18'h00080,
    S_DX_W  = 18'h00100,
    S_DY    = 18'h00200,
    S_DY_W  = 18'h00400,
    S_SIDEX = 18'h00800,
    S_SIDEY = 18'h01000,
    S_STEP  = 18'h02000,
    S_CHECK = 18'h04000,
    S_HT    = 18'h08000,
    S_HT_W  = 18'h10000,
    S_EMIT  = 18'h20000
  } state_e;

  state_e state_q;
  state_e state_d;
  cmd_e   cmd;

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o      = cmd;

  always_comb begin
    state_d = state_q;
    cmd     = CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd     = CMD_LOAD;
          state_d = stat_i.in_op ? S_WRITE : S_CAM;
        end
      end
      S_WRITE: begin
        cmd     = CMD_WRITE;
        state_d = S_EMIT;
      end
      S_CAM: begin
        cmd     = CMD_CAM_SET;
        state_d = S_MULX;
      end
      S_MULX: begin
        cmd     = CMD_MULX;
        state_d = S_MULY;
      end
      S_MULY: begin
        cmd     = CMD_MULY;
        state_d = S_RAY;
      end
      S_RAY: begin
        cmd     = CMD_RAY;
        state_d = S_DX;
      end
      S_DX: begin
        cmd     = CMD_DX_DIV;
        state_d = S_DX_W;
      end
      S_DX_W: begin
        if (stat_i.div_done) begin
          cmd     = CMD_DX_SET;
          state_d = S_DY;
        end
      end
      S_DY: begin
        cmd     = CMD_DY_DIV;
        state_d = S_DY_W;
      end
      S_DY_W: begin
        if (stat_i.div_done) begin
          cmd     = CMD_DY_SET;
          state_d = S_SIDEX;
        end
      end
      S_SIDEX: begin
        cmd     = CMD_SIDE_X;
        state_d = S_SIDEY;
      end
      S_SIDEY: begin
        cmd     = CMD_SIDE_Y;
        state_d = S_STEP;
      end
      S_STEP: begin
        cmd     = CMD_STEP;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        state_d = stat_i.hit ? S_HT : S_STEP;
      end
      S_HT: begin
        cmd     = CMD_H_DIV;
        state_d = S_HT_W;
      end
      S_HT_W: begin
        if (stat_i.div_done) begin
          cmd     = CMD_H_SET;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd     = CMD_EMIT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/rgd_datapath.sv -----
// Raycaster datapath: ray setup, DDA walk, wall map and line span.
module rgd_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rgd_pkg::cmd_e              cmd_i,
  input  rgd_pkg::cfg_t              cfg_i,
  input  logic                       op_i,
  input  logic [rgd_pkg::COL_W-1:0]  column_i,
  input  logic [rgd_pkg::CELL_W-1:0] cell_x_i,
  input  logic [rgd_pkg::CELL_W-1:0] cell_y_i,
  input  logic                       cell_wall_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [rgd_pkg::COL_W-1:0]  col_out_o,
  output logic [rgd_pkg::PIX_W-1:0]  draw_start_o,
  output logic [rgd_pkg::PIX_W-1:0]  draw_end_o,
  output logic                       hit_side_o,
  output logic                       write_done_o,
  output rgd_pkg::status_t           stat_o
);
  import rgd_pkg::*;

  logic [COL_W-1:0]         col_q;
  logic [CELL_W-1:0]        cx_q;
  logic [CELL_W-1:0]        cy_q;
  logic                     cw_q;
  logic signed [CAM_W-1:0]  cam_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [RAY_W-1:0]         rx_q;
  logic [RAY_W-1:0]         ry_q;
  logic [DLT_W-1:0]         dx_q;
  logic [DLT_W-1:0]         dy_q;
  logic [SD_W-1:0]          sx_q;
  logic [SD_W-1:0]          sy_q;
  logic [SD_W-1:0]          perp_q;
  logic [MC_W-1:0]          mx_q;
  logic [MC_W-1:0]          my_q;
  logic                     side_q;
  logic [WALK_W-1:0]        n_q;
  logic                     oob_q;
  logic                     rd_bit_q;
  logic                     rd_vld_q;
  logic                     rd_rst_q;
  logic [COL_W-1:0]         res_col_q;
  logic [PIX_W-1:0]         res_start_q;
  logic [PIX_W-1:0]         res_end_q;
  logic                     res_side_q;
  logic                     res_done_q;
  logic                     out_valid_q;
  logic [COL_W-1:0]         out_col_q;
  logic [PIX_W-1:0]         out_start_q;
  logic [PIX_W-1:0]         out_end_q;
  logic                     out_side_q;
  logic                     out_done_q;

  logic                     map_q [CELLS];
  logic [CELLS-1:0]         vld_q;

  logic                     div_start;
  logic [DIV_W-1:0]         div_dividend;
  logic [DIV_W-1:0]         div_divisor;
  logic [DIV_W-1:0]         quo;
  logic                     div_done;

  logic [SC_W-1:0]          c_ext;
  logic [SC_W-1:0]          c_clamp;
  logic [SC_W-1:0]          two_c;
  logic                     c_neg;
  logic [SC_W-1:0]          c_mag;
  logic [CPR_W-1:0]         cam_prod;
  logic [CAM_W-1:0]         qc;
  logic [RAY_W-1:0]         rx_mag;
  logic [RAY_W-1:0]         ry_mag;
  logic [RAY_W-1:0]         dir_x_ext;
  logic [RAY_W-1:0]         dir_y_ext;
  logic [FRC_W-1:0]         fxp;
  logic [FRC_W-1:0]         fyp;
  logic [FRC_W+DQ_W-1:0]    sx_prod;
  logic [FRC_W+DQ_W-1:0]    sy_prod;
  logic                     take_x;
  logic [MC_W-1:0]          mx_n;
  logic [MC_W-1:0]          my_n;
  logic                     oob_n;
  logic [ADDR_W-1:0]        rd_addr;
  logic [ADDR_W-1:0]        wr_addr;
  logic                     interior;
  logic                     wall;
  logic [HT_W-1:0]          height;
  logic [HT_W-1:0]          half;
  logic [HT_W-1:0]          lo;
  logic [HT_W-1:0]          hi;

  localparam logic [DLT_W-1:0] DELTA_SAT = {1'b1, {(DLT_W - 1){1'b0}}};

  rgd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  // camera coordinate: |2c - W| * 2^14 / W, sign applied afterwards
  assign c_ext    = SC_W'(col_q);
  assign c_clamp  = (c_ext > SC_W'(SCREEN_W - 1)) ? SC_W'(SCREEN_W - 1) : c_ext;
  assign two_c    = c_clamp << 1;
  assign c_neg    = two_c < SC_W'(SCREEN_W);
  assign c_mag    = c_neg ? (SC_W'(SCREEN_W) - two_c) : (two_c - SC_W'(SCREEN_W));
  assign cam_prod = CPR_W'(c_mag) * CPR_W'(RCP_W'(CAM_RCP));
  assign qc       = cam_prod[CAM_SH +: CAM_W];

  assign rx_mag    = rx_q[RAY_W-1] ? (~rx_q + 1'b1) : rx_q;
  assign ry_mag    = ry_q[RAY_W-1] ? (~ry_q + 1'b1) : ry_q;
  assign dir_x_ext = {{(RAY_W - VEC_W){cfg_i.dir_x[VEC_W-1]}}, cfg_i.dir_x};
  assign dir_y_ext = {{(RAY_W - VEC_W){cfg_i.dir_y[VEC_W-1]}}, cfg_i.dir_y};

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (cmd_i)
      CMD_DX_DIV: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(1) << 30;
        div_divisor  = DIV_W'(rx_mag);
      end
      CMD_DY_DIV: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(1) << 30;
        div_divisor  = DIV_W'(ry_mag);
      end
      CMD_H_DIV: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(SCREEN_H) << 28;
        div_divisor  = perp_q[DIV_W-1:0];
      end
      default: ;
    endcase
  end

  // distance to the first grid line on each axis
  assign fxp     = rx_q[RAY_W-1] ? FRC_W'(cfg_i.pos_x[FRAC_W-1:0])
                                 : FRC_W'(FRAC_ONE) - FRC_W'(cfg_i.pos_x[FRAC_W-1:0]);
  assign fyp     = ry_q[RAY_W-1] ? FRC_W'(cfg_i.pos_y[FRAC_W-1:0])
                                 : FRC_W'(FRAC_ONE) - FRC_W'(cfg_i.pos_y[FRAC_W-1:0]);
  assign sx_prod = fxp * dx_q[DQ_W-1:0];
  assign sy_prod = fyp * dy_q[DQ_W-1:0];

  // DDA step
  assign take_x = sx_q < sy_q;
  assign mx_n   = take_x ? (mx_q + (rx_q[RAY_W-1] ? {MC_W{1'b1}} : MC_W'(1))) : mx_q;
  assign my_n   = take_x ? my_q : (my_q + (ry_q[RAY_W-1] ? {MC_W{1'b1}} : MC_W'(1)));
  assign oob_n  = mx_n[MC_W-1] || my_n[MC_W-1] ||
                  (mx_n >= MC_W'(GRID_W)) || (my_n >= MC_W'(GRID_H));
  assign rd_addr = ADDR_W'(ADDR_W'(my_n[GY_W-1:0]) * ADDR_W'(GRID_W))
                   + ADDR_W'(mx_n[GX_W-1:0]);
  assign wr_addr = ADDR_W'(ADDR_W'(cy_q) * ADDR_W'(GRID_W)) + ADDR_W'(cx_q);
  assign interior = (int'(cx_q) > 0) && (int'(cx_q) < GRID_W - 1) &&
                    (int'(cy_q) > 0) && (int'(cy_q) < GRID_H - 1);
  assign wall = oob_q | (rd_vld_q ? rd_bit_q : rd_rst_q);

  // line height, saturated at twice the screen height
  always_comb begin
    if (perp_q == '0) begin
      height = HT_W'(2 * SCREEN_H);
    end else if (perp_q[SD_W-1:DIV_W] != '0) begin
      height = '0;
    end else if (quo > DIV_W'(2 * SCREEN_H)) begin
      height = HT_W'(2 * SCREEN_H);
    end else begin
      height = quo[HT_W-1:0];
    end
    half = height >> 1;
    lo   = (half >= HT_W'(HALF_H)) ? '0 : (HT_W'(HALF_H) - half);
    hi   = ((HT_W'(HALF_H) + half) >= HT_W'(SCREEN_H)) ? HT_W'(SCREEN_H - 1)
                                                       : (HT_W'(HALF_H) + half);
  end

  always_ff @(posedge clk_i) begin
    rd_bit_q <= map_q[rd_addr];
    rd_vld_q <= vld_q[rd_addr];
    rd_rst_q <= reset_wall(mx_n, my_n);
    if (cmd_i == CMD_WRITE && interior) begin
      map_q[wr_addr] <= cw_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i == CMD_WRITE && interior) begin
      vld_q[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        col_q <= column_i;
        cx_q  <= cell_x_i;
        cy_q  <= cell_y_i;
        cw_q  <= cell_wall_i;
      end
      CMD_WRITE: begin
        res_col_q   <= '0;
        res_start_q <= '0;
        res_end_q   <= '0;
        res_side_q  <= 1'b0;
        res_done_q  <= interior;
      end
      CMD_CAM_SET: cam_q <= c_neg ? (~qc + 1'b1) : qc;
      CMD_MULX: prod_q <= $signed(cfg_i.plane_x) * cam_q;
      CMD_MULY: begin
        rx_q   <= dir_x_ext + prod_q[PROD_W-1:VEC_FRAC];
        prod_q <= $signed(cfg_i.plane_y) * cam_q;
      end
      CMD_RAY: ry_q <= dir_y_ext + prod_q[PROD_W-1:VEC_FRAC];
      CMD_DX_SET: dx_q <= (rx_q == '0) ? DELTA_SAT : DLT_W'(quo);
      CMD_DY_SET: dy_q <= (ry_q == '0) ? DELTA_SAT : DLT_W'(quo);
      CMD_SIDE_X: begin
        mx_q <= MC_W'(cfg_i.pos_x[POS_W-1:FRAC_W]);
        sx_q <= (rx_q == '0) ? SD_W'({fxp, 40'd0}) : SD_W'(sx_prod);
      end
      CMD_SIDE_Y: begin
        my_q   <= MC_W'(cfg_i.pos_y[POS_W-1:FRAC_W]);
        sy_q   <= (ry_q == '0) ? SD_W'({fyp, 40'd0}) : SD_W'(sy_prod);
        perp_q <= '0;
        side_q <= 1'b0;
        n_q    <= '0;
      end
      CMD_STEP: begin
        if (take_x) begin
          perp_q <= sx_q;
          sx_q   <= sx_q + (SD_W'(dx_q) << FRAC_W);
          side_q <= 1'b0;
        end else begin
          perp_q <= sy_q;
          sy_q   <= sy_q + (SD_W'(dy_q) << FRAC_W);
          side_q <= 1'b1;
        end
        mx_q  <= mx_n;
        my_q  <= my_n;
        oob_q <= oob_n;
        n_q   <= n_q + 1'b1;
      end
      CMD_H_SET: begin
        res_col_q   <= col_q;
        res_start_q <= PIX_W'(lo);
        res_end_q   <= PIX_W'(hi);
        res_side_q  <= side_q;
        res_done_q  <= 1'b0;
      end
      CMD_EMIT: begin
        out_col_q   <= res_col_q;
        out_start_q <= res_start_q;
        out_end_q   <= res_end_q;
        out_side_q  <= res_side_q;
        out_done_q  <= res_done_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i == CMD_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign col_out_o    = out_col_q;
  assign draw_start_o = out_start_q;
  assign draw_end_o   = out_end_q;
  assign hit_side_o   = out_side_q;
  assign write_done_o = out_done_q;

  assign stat_o.in_op    = op_i;
  assign stat_o.div_done = div_done;
  assign stat_o.hit      = wall || (n_q == WALK_W'(WALK_LIMIT));
  assign stat_o.out_free = !out_valid_q || out_ready_i;

endmodule

// ----- rtl/core/grid_dda_raycaster.sv -----
// Grid DDA raycaster top level: one wall span per cast column, map cell writes.
// A cast walks 1 to GRID_W+GRID_H+2 DDA steps from acceptance to result; casts and map
// writes both stall while the previous result still waits on the output. The cast time
// is set by the shared restoring divider, which produces one quotient bit per cycle and
// runs three times per cast (two ray reciprocals, line height), and by the registered
// wall map read, checked in its own state after each step; the camera coordinate comes
// from a reciprocal multiply registered in cam_q. One word is in flight at a time; a
// finished result waits in the output register while the next word is accepted. Map
// cells outside the grid read as walls, border writes are refused with write_done low,
// and configuration writes are taken in any cycle.
`include "assert_macros.svh"

module grid_dda_raycaster (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rgd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rgd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           op_i,
  input  logic [rgd_pkg::COL_W-1:0]      column_i,
  input  logic [rgd_pkg::CELL_W-1:0]     cell_x_i,
  input  logic [rgd_pkg::CELL_W-1:0]     cell_y_i,
  input  logic                           cell_wall_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [rgd_pkg::COL_W-1:0]      col_out_o,
  output logic [rgd_pkg::PIX_W-1:0]      draw_start_o,
  output logic [rgd_pkg::PIX_W-1:0]      draw_end_o,
  output logic                           hit_side_o,
  output logic                           write_done_o
);
  import rgd_pkg::*;

  cfg_t    cfg;
  cmd_e    cmd;
  status_t stat;

  rgd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rgd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rgd_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_i        (cfg),
    .op_i         (op_i),
    .column_i     (column_i),
    .cell_x_i     (cell_x_i),
    .cell_y_i     (cell_y_i),
    .cell_wall_i  (cell_wall_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .col_out_o    (col_out_o),
    .draw_start_o (draw_start_o),
    .draw_end_o   (draw_end_o),
    .hit_side_o   (hit_side_o),
    .write_done_o (write_done_o),
    .stat_o       (stat)
  );

  `RGD_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o)
  `RGD_ASSERT(a_result_from_busy, clk_i, rst_ni, $rose(out_valid_o) |-> $past(!in_ready_o))
  `RGD_ASSERT_NEVER(a_write_span_zero, clk_i, rst_ni, out_valid_o && write_done_o && (draw_start_o != 0 || draw_end_o != 0 || hit_side_o))
  `RGD_ASSERT_NEVER(a_span_order, clk_i, rst_ni, out_valid_o && !write_done_o && draw_start_o > draw_end_o)

endmodule
